>>> src/command_frame_parser_macros.svh
// Assertion macros shared by the command frame parser RTL.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef COMMAND_FRAME_PARSER_MACROS_SVH
`define COMMAND_FRAME_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/cfp_pkg.sv
// Types, constants and small decode tables for the command frame parser.
// Used by cfp_parser, cfp_store, cfp_emitter and command_frame_parser.
`default_nettype none

package cfp_pkg;

    localparam int KEPT_PAYLOAD = 18;
    localparam int STORE_WORDS  = KEPT_PAYLOAD / 2;
    localparam int ADDR_W       = $clog2(STORE_WORDS);
    localparam int COUNT_W      = $clog2(KEPT_PAYLOAD + 1);
    localparam int STEP_W       = 4;

    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'hAF;
    localparam logic [7:0] FUNC_BOUND  = 8'hF1;

    localparam logic [7:0] FN_CAL         = 8'h01;
    localparam logic [7:0] FN_PID         = 8'h02;
    localparam logic [7:0] FN_RATE_GAIN   = 8'h10;
    localparam logic [7:0] FN_ANGLE_GAIN  = 8'h11;
    localparam logic [7:0] FN_RATE_LIMIT  = 8'h12;
    localparam logic [7:0] FN_ANGLE_LIMIT = 8'h13;

    localparam logic [7:0] SUB_ACCEL = 8'h01;
    localparam logic [7:0] SUB_GYRO  = 8'h02;
    localparam logic [7:0] SUB_MAG   = 8'h04;
    localparam logic [7:0] SUB_PID   = 8'h01;

    localparam logic [STEP_W-1:0] GAIN_ACK_STEP  = 4'd9;
    localparam logic [STEP_W-1:0] LIMIT_ACK_STEP = 4'd3;

    typedef enum logic [3:0] {
        ACT_ACCEL_CAL   = 4'd0,
        ACT_GYRO_CAL    = 4'd1,
        ACT_MAG_FLAG    = 4'd2,
        ACT_PID_READ    = 4'd3,
        ACT_RATE_GAIN   = 4'd4,
        ACT_ANGLE_GAIN  = 4'd5,
        ACT_RATE_LIMIT  = 4'd6,
        ACT_ANGLE_LIMIT = 4'd7,
        ACT_ACK         = 4'd8
    } t_action;

    typedef enum logic [2:0] {
        PS_IDLE    = 3'd0,
        PS_SYNC    = 3'd1,
        PS_FUNC    = 3'd2,
        PS_LEN     = 3'd3,
        PS_PAYLOAD = 3'd4,
        PS_CHECK   = 3'd5
    } t_parse;

    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_CAL   = 3'd1,
        KIND_PID   = 3'd2,
        KIND_GAIN  = 3'd3,
        KIND_LIMIT = 3'd4
    } t_kind;

    // Payload store write port: clr wipes the valid bits at a frame start.
    typedef struct packed {
        logic              clr;
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic              lo;
        logic [7:0]        data;
    } t_wr;

    // Handed from the parser to the emitter when a checksum matches.
    typedef struct packed {
        logic       start;
        logic [7:0] func;
        logic [7:0] sum;
    } t_start;

    typedef struct packed {
        t_action            action;
        logic [1:0]         axis;
        logic [1:0]         term;
        logic signed [15:0] value;
        logic               mag_flag;
        logic [7:0]         ack_function;
        logic [7:0]         ack_sum;
        logic               last;
    } t_result;

    function automatic t_kind func_kind(input logic [7:0] f);
        t_kind k;
        case (f)
            FN_CAL:                        k = KIND_CAL;
            FN_PID:                        k = KIND_PID;
            FN_RATE_GAIN, FN_ANGLE_GAIN:   k = KIND_GAIN;
            FN_RATE_LIMIT, FN_ANGLE_LIMIT: k = KIND_LIMIT;
            default:                       k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [1:0] gain_axis(input logic [STEP_W-1:0] i);
        logic [1:0] a;
        case (i)
            4'd0, 4'd1, 4'd2: a = 2'd0;
            4'd3, 4'd4, 4'd5: a = 2'd1;
            default:          a = 2'd2;
        endcase
        return a;
    endfunction

    function automatic logic [1:0] gain_term(input logic [STEP_W-1:0] i);
        logic [1:0] t;
        case (i)
            4'd0, 4'd3, 4'd6: t = 2'd0;
            4'd1, 4'd4, 4'd7: t = 2'd1;
            default:          t = 2'd2;
        endcase
        return t;
    endfunction

    // Limit for axis a sits in payload bytes 6a+2 and 6a+3, i.e. word 3a+1.
    function automatic logic [ADDR_W-1:0] limit_word(input logic [STEP_W-1:0] i);
        logic [ADDR_W-1:0] w;
        case (i)
            4'd0:    w = 4'd1;
            4'd1:    w = 4'd4;
            default: w = 4'd7;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> src/cfp_store.sv
// Payload store: nine 16-bit words with byte-lane writes and a registered read.
// Depends on cfp_pkg; per-byte valid bits make unreceived bytes read as zero.
`default_nettype none

module cfp_store (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire cfp_pkg::t_wr             i_wr,
    input  wire                           i_rd_en,
    input  wire [cfp_pkg::ADDR_W-1:0]     i_rd_addr,
    output logic [15:0]                   o_rd_data
);
    import cfp_pkg::*;

    logic [15:0]             mem [STORE_WORDS];
    logic [KEPT_PAYLOAD-1:0] r_valid;
    logic [15:0]             r_rdata;
    logic [1:0]              r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            if (i_wr.lo) begin
                mem[i_wr.addr][7:0] <= i_wr.data;
            end else begin
                mem[i_wr.addr][15:8] <= i_wr.data;
            end
        end
        if (i_rd_en) begin
            r_rdata <= mem[i_rd_addr];
            r_rvld  <= {r_valid[{i_rd_addr, 1'b0}], r_valid[{i_rd_addr, 1'b1}]};
        end
    end

    // The high byte of a word is the even payload byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.clr) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[{i_wr.addr, i_wr.lo}] <= 1'b1;
        end
    end

    assign o_rd_data = {r_rvld[1] ? r_rdata[15:8] : 8'h00,
                        r_rvld[0] ? r_rdata[7:0]  : 8'h00};

endmodule

`default_nettype wire

>>> src/cfp_parser.sv
// Byte-level frame recogniser: header, function, length, payload and checksum.
// Depends on cfp_pkg; writes payload bytes into cfp_store and starts cfp_emitter.
`default_nettype none

module cfp_parser #(
    parameter int MAX_LENGTH = 50
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    input  wire [7:0]       i_byte,
    output cfp_pkg::t_wr    o_wr,
    output cfp_pkg::t_start o_start
);
    import cfp_pkg::*;

    localparam int         LEFT_W    = $clog2(MAX_LENGTH);
    localparam logic [8:0] LEN_BOUND = 9'(MAX_LENGTH);

    t_parse              r_state, n_state;
    logic [7:0]          r_func, n_func;
    logic [7:0]          r_sum, n_sum;
    logic [LEFT_W-1:0]   r_left, n_left;
    logic [COUNT_W-1:0]  r_count, n_count;

    logic [7:0] sum_next;
    logic       len_ok;

    assign sum_next = r_sum + i_byte;
    assign len_ok   = ({1'b0, i_byte} < LEN_BOUND);

    always_comb begin
        n_state = r_state;
        if (i_valid) begin
            case (r_state)
                PS_IDLE:    n_state = (i_byte == SYNC_FIRST) ? PS_SYNC : PS_IDLE;
                PS_SYNC:    n_state = (i_byte == SYNC_SECOND) ? PS_FUNC : PS_IDLE;
                PS_FUNC:    n_state = (i_byte < FUNC_BOUND) ? PS_LEN : PS_IDLE;
                PS_LEN:     n_state = len_ok ? PS_PAYLOAD : PS_IDLE;
                PS_PAYLOAD: begin
                    // A zero-length frame swallows the next byte and goes idle.
                    if (r_left == '0) begin
                        n_state = PS_IDLE;
                    end else if (r_left == LEFT_W'(1)) begin
                        n_state = PS_CHECK;
                    end else begin
                        n_state = PS_PAYLOAD;
                    end
                end
                default:    n_state = PS_IDLE;
            endcase
        end
    end

    always_comb begin
        n_func  = r_func;
        n_sum   = r_sum;
        n_left  = r_left;
        n_count = r_count;
        o_wr    = '0;
        o_start = '0;
        o_wr.addr = r_count[COUNT_W-1:1];
        o_wr.lo   = r_count[0];
        o_wr.data = i_byte;
        o_start.func = r_func;
        o_start.sum  = r_sum;
        if (i_valid) begin
            case (r_state)
                PS_IDLE: begin
                    if (i_byte == SYNC_FIRST) begin
                        n_sum    = i_byte;
                        n_count  = '0;
                        n_left   = '0;
                        o_wr.clr = 1'b1;
                    end
                end
                PS_SYNC: begin
                    if (i_byte == SYNC_SECOND) begin
                        n_sum = sum_next;
                    end
                end
                PS_FUNC: begin
                    if (i_byte < FUNC_BOUND) begin
                        n_func = i_byte;
                        n_sum  = sum_next;
                    end
                end
                PS_LEN: begin
                    if (len_ok) begin
                        n_left  = i_byte[LEFT_W-1:0];
                        n_count = '0;
                        n_sum   = sum_next;
                    end
                end
                PS_PAYLOAD: begin
                    if (r_left != '0) begin
                        n_left = r_left - LEFT_W'(1);
                        n_sum  = sum_next;
                        if (r_count != COUNT_W'(KEPT_PAYLOAD)) begin
                            o_wr.en = 1'b1;
                            n_count = r_count + COUNT_W'(1);
                        end
                    end
                end
                PS_CHECK: begin
                    o_start.start = (i_byte == r_sum);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PS_IDLE;
            r_func  <= '0;
            r_sum   <= '0;
            r_left  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_func  <= n_func;
            r_sum   <= n_sum;
            r_left  <= n_left;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

>>> src/cfp_emitter.sv
// Result sequencer: walks the payload store word by word and formats results.
// Depends on cfp_pkg; reads cfp_store through its registered read port.
`default_nettype none

module cfp_emitter (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire cfp_pkg::t_start       i_start,
    output logic                       o_busy,
    output logic                       o_rd_en,
    output logic [cfp_pkg::ADDR_W-1:0] o_rd_addr,
    input  wire [15:0]                 i_rd_data,
    output logic                       o_valid,
    input  wire                        i_ready,
    output cfp_pkg::t_result           o_result
);
    import cfp_pkg::*;

    typedef struct packed {
        logic              valid;
        logic [STEP_W-1:0] step;
        logic              ack;
        logic              last;
    } t_meta;

    logic              r_active;
    t_kind             r_kind;
    logic [7:0]        r_func;
    logic [7:0]        r_sum;
    logic [STEP_W-1:0] r_step;
    t_meta             r_rd;
    logic              r_out_valid;
    t_result           r_out;
    logic              r_mag;

    logic    adv;
    logic    is_final;
    logic    is_ack;
    t_result n_res;
    logic    n_res_valid;
    logic    toggle;
    logic [7:0] first;

    // The whole pipe moves together; it stalls only on a full output register.
    assign adv = !r_out_valid || i_ready;

    always_comb begin
        is_ack    = 1'b0;
        is_final  = 1'b0;
        o_rd_addr = '0;
        case (r_kind)
            KIND_GAIN: begin
                o_rd_addr = r_step[ADDR_W-1:0];
                is_ack    = (r_step == GAIN_ACK_STEP);
                is_final  = is_ack;
            end
            KIND_LIMIT: begin
                o_rd_addr = limit_word(r_step);
                is_ack    = (r_step == LIMIT_ACK_STEP);
                is_final  = is_ack;
            end
            default: begin
                is_final = 1'b1;
            end
        endcase
    end

    assign o_rd_en = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_rd     <= '0;
            r_step   <= '0;
            r_kind   <= KIND_NONE;
        end else begin
            if (i_start.start && (func_kind(i_start.func) != KIND_NONE)) begin
                r_active <= 1'b1;
                r_step   <= '0;
                r_kind   <= func_kind(i_start.func);
            end else if (adv && r_active) begin
                r_step <= r_step + STEP_W'(1);
                if (is_final) begin
                    r_active <= 1'b0;
                end
            end
            if (adv) begin
                r_rd.valid <= r_active;
                r_rd.step  <= r_step;
                r_rd.ack   <= is_ack;
                r_rd.last  <= is_final;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start.start) begin
            r_func <= i_start.func;
            r_sum  <= i_start.sum;
        end
    end

    assign first = i_rd_data[15:8];

    always_comb begin
        n_res       = '0;
        n_res_valid = r_rd.valid;
        toggle      = 1'b0;
        n_res.last  = r_rd.last;
        if (r_rd.ack) begin
            n_res.action       = ACT_ACK;
            n_res.ack_function = r_func;
            n_res.ack_sum      = r_sum;
        end else begin
            case (r_kind)
                KIND_CAL: begin
                    if (first == SUB_ACCEL) begin
                        n_res.action = ACT_ACCEL_CAL;
                    end else if (first == SUB_GYRO) begin
                        n_res.action = ACT_GYRO_CAL;
                    end else if (first == SUB_MAG) begin
                        n_res.action   = ACT_MAG_FLAG;
                        n_res.mag_flag = !r_mag;
                        toggle         = r_rd.valid;
                    end else begin
                        n_res_valid = 1'b0;
                    end
                end
                KIND_PID: begin
                    n_res.action = ACT_PID_READ;
                    n_res_valid  = r_rd.valid && (first == SUB_PID);
                end
                KIND_GAIN: begin
                    n_res.action = r_func[0] ? ACT_ANGLE_GAIN : ACT_RATE_GAIN;
                    n_res.axis   = gain_axis(r_rd.step);
                    n_res.term   = gain_term(r_rd.step);
                    n_res.value  = signed'(i_rd_data);
                end
                KIND_LIMIT: begin
                    n_res.action = r_func[0] ? ACT_ANGLE_LIMIT : ACT_RATE_LIMIT;
                    n_res.axis   = r_rd.step[1:0];
                    n_res.value  = signed'(i_rd_data);
                end
                default: begin
                    n_res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_mag       <= 1'b0;
        end else if (adv) begin
            r_out_valid <= n_res_valid;
            if (toggle) begin
                r_mag <= !r_mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_res;
        end
    end

    assign o_busy   = r_active || r_rd.valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

>>> src/command_frame_parser.sv
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] rx_byte
// m_axis    out        tdata[40:0] result fields, tlast = last result of the byte
//
// A byte is taken every cycle, except after the checksum byte of a good frame with a
// known function code: the input is then held while the sequencer is active and while
// the store read of its last step is still in the read register.
// Results leave one per cycle through an output register; a stall there holds the
// sequencer and the store read and so lengthens the hold on the input.
// Reset is synchronous and active low.
// Top level of the command frame parser; depends on cfp_pkg and the three submodules.
`default_nettype none
`include "command_frame_parser_macros.svh"

module command_frame_parser #(
    parameter int MAX_LENGTH = 50
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire [7:0]   i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // [3:0] action, [5:4] axis, [7:6] term, [23:8] value, [24] mag_flag,
    // [32:25] ack_function, [40:33] ack_sum, [47:41] zero
    output logic [47:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast
);
    import cfp_pkg::*;

    t_wr               wr;
    t_start            start;
    logic              emit_busy;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [15:0]       rd_data;
    t_result           result;
    logic              in_fire;
    logic              start_known;
    logic              ack_out;

    assign o_s_axis_tready = !emit_busy;
    assign in_fire         = i_s_axis_tvalid && !emit_busy;

    cfp_parser #(
        .MAX_LENGTH(MAX_LENGTH)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_fire),
        .i_byte  (i_s_axis_tdata),
        .o_wr    (wr),
        .o_start (start)
    );

    cfp_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    cfp_emitter u_emitter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .o_busy    (emit_busy),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_result  (result)
    );

    assign o_m_axis_tdata = {7'd0, result.ack_sum, result.ack_function, result.mag_flag,
                             result.value, result.term, result.axis, result.action};
    assign o_m_axis_tlast = result.last;

    assign start_known = start.start && (func_kind(start.func) != KIND_NONE);
    assign ack_out     = o_m_axis_tvalid && (result.action == ACT_ACK);

    // A decodable good frame must hold off the input from the next cycle on.
    `CFP_ASSERT_NEXT(a_start_sets_busy, start_known, emit_busy, "decode start left input open")
    // The store is never written or cleared while the sequencer may read it.
    `CFP_ASSERT_NOW(a_no_write_when_busy, wr.en || wr.clr, !emit_busy, "store write while busy")
    // An acknowledge always closes the results of its byte.
    `CFP_ASSERT_NOW(a_ack_is_last, ack_out, o_m_axis_tlast, "acknowledge without tlast")

endmodule

`default_nettype wire
